### rtl/core/htw_pkg.sv
// ============================================================================
// Hierarchical timer wheel package
// Shared sizes, codes and transaction types for the timer wheel.
// ============================================================================
package htw_pkg;

    localparam int ROOT_BITS   = 8;
    localparam int LEVEL_BITS  = 6;
    localparam int NUM_LEVELS  = 5;
    localparam int NUM_TIMERS  = 64;

    localparam int ROOT_SIZE   = 1 << ROOT_BITS;
    localparam int LEVEL_SIZE  = 1 << LEVEL_BITS;
    localparam int NUM_BUCKETS = ROOT_SIZE + (NUM_LEVELS - 1) * LEVEL_SIZE;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int PTR_W       = $clog2(NUM_TIMERS + 1);
    localparam int ID_W        = 6;
    localparam int CNT_W       = 7;
    localparam int TICK_W      = 32;
    localparam int LVI_W       = (NUM_LEVELS > 2) ? $clog2(NUM_LEVELS - 1) : 1;

    // End-of-list marker for bucket heads, tails and links.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_TIMERS);

    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_ARMED    = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED  = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   timer_id;
        logic [TICK_W-1:0] timeout;
    } in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  timer_id_res;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] peak_count;
        logic             last;
    } out_t;

endpackage

### rtl/core/htw_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/htw_bucket_sel.sv
// ============================================================================
// Timer wheel bucket selector
// Maps an expiry tick to its bucket by its distance from the current tick.
// ============================================================================
module htw_bucket_sel (
    input  logic [htw_pkg::TICK_W-1:0] expiry,
    input  logic [htw_pkg::TICK_W-1:0] tick,
    output logic [htw_pkg::BKT_W-1:0]  bucket
);
    import htw_pkg::*;

    logic [TICK_W-1:0]     diff;
    logic [63:0]           d64;
    logic [63:0]           e64;
    logic [63:0]           sh;
    logic [LEVEL_BITS-1:0] idx;

    always_comb
    begin
        diff   = expiry - tick;
        d64    = {32'b0, diff};
        e64    = {32'b0, expiry};
        bucket = '0;
        sh     = '0;
        idx    = '0;
        if (diff[TICK_W-1])
        begin
            // A distance of half the tick range or more counts as past due.
            bucket = BKT_W'(tick[ROOT_BITS-1:0]);
        end
        else if ((d64 >> ROOT_BITS) == 64'd0)
        begin
            bucket = BKT_W'(expiry[ROOT_BITS-1:0]);
        end
        else
        begin
            bucket = BKT_W'(ROOT_SIZE + (NUM_LEVELS - 2) * LEVEL_SIZE);
            sh     = e64 >> (ROOT_BITS + (NUM_LEVELS - 2) * LEVEL_BITS);
            idx    = sh[LEVEL_BITS-1:0];
            for (int k = NUM_LEVELS - 2; k >= 1; k--)
            begin
                if ((d64 >> (ROOT_BITS + k * LEVEL_BITS)) == 64'd0)
                begin
                    bucket = BKT_W'(ROOT_SIZE + (k - 1) * LEVEL_SIZE);
                    sh     = e64 >> (ROOT_BITS + (k - 1) * LEVEL_BITS);
                    idx    = sh[LEVEL_BITS-1:0];
                end
            end
            bucket = bucket + BKT_W'(idx);
        end
    end

endmodule

### rtl/core/hierarchical_timer_wheel_top.sv
// ============================================================================
// Hierarchical timer wheel
// Five-level cascading timing wheel over a pool of 64 timer slots.
// ============================================================================
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one command per
// transaction: arm a timer id with a timeout, or advance the wheel by one tick.
// The output channel (out_valid, out_ready, out_data) returns the results.
// An arm yields one result: armed or rejected. A tick yields one expired
// result per timer in the current root bucket, in insertion order, with last
// set on the final one, or a single "none expired" result.
// The block works on one command at a time and raises in_ready only when idle.
// An accepted arm is placed through S_PLACE0, S_PLACE1 and S_PLACED, with
// S_PLACE2 added when its bucket already holds timers; a rejected arm shows
// its result in the cycle after acceptance. A tick drains the current root
// bucket through S_DRAIN0 and S_DRAIN1, then reads one timer at a time;
// each further expired result follows only after the previous one is taken.
// When the root position wraps, the tick first cascades coarser levels,
// relocating each of their timers into its new bucket, before the drain.
// in_ready returns in the cycle after the final result is taken, or, after
// the final expired result of a tick, once S_DRAIN_NEXT has been passed.
// Every result waits in an output register until it is taken, so a stalled
// receiver simply holds the sequencer. After reset the bucket head and tail
// memories are cleared by a pass over all 512 buckets, during which in_ready is low.
// All timing comes from one sequencer sharing single-port-read memories and
// one bucket selector.
// ============================================================================
module hierarchical_timer_wheel_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  htw_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output htw_pkg::out_t  out_data
);
    import htw_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PLACE0,
        S_PLACE1,
        S_PLACE2,
        S_PLACED,
        S_CAS0,
        S_CAS1,
        S_CAS_NEXT,
        S_CAS_RD,
        S_DRAIN0,
        S_DRAIN1,
        S_DRAIN_NEXT,
        S_DRAIN_RD,
        S_OUT
    } state_t;

    state_t                state_reg;
    state_t                ret_reg;
    logic [PTR_W-1:0]      cur_reg;
    logic [PTR_W-1:0]      nxt_reg;
    logic [PTR_W-1:0]      tmp_reg;
    logic [TICK_W-1:0]     exp_reg;
    logic [BKT_W-1:0]      bkt_reg;
    logic [BKT_W-1:0]      clr_reg;
    logic [LVI_W-1:0]      lvi_reg;
    logic                  cas_reg;
    logic                  any_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [LEVEL_BITS-1:0] lpos_reg [NUM_LEVELS-1];
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [CNT_W-1:0]      active_reg;
    logic [CNT_W-1:0]      peak_reg;
    logic                  out_valid_reg;
    out_t                  out_data_reg;

    // Memory ports.
    logic             head_we, tail_we, next_we, exp_we;
    logic [BKT_W-1:0] head_waddr, tail_waddr, head_raddr;
    logic [PTR_W-1:0] head_wdata, tail_wdata, next_wdata;
    logic [PTR_W-1:0] head_rd, tail_rd, next_rd;
    logic [ID_W-1:0]  next_waddr, exp_waddr;
    logic [TICK_W-1:0] exp_wdata, exp_rd, arm_expiry;

    logic [BKT_W-1:0]      bsel;
    logic [BKT_W-1:0]      cas_bkt;
    logic [LEVEL_BITS-1:0] lpos_inc;
    logic                  in_acc;
    logic                  arm_reject;
    logic [CNT_W-1:0]      act_inc;
    logic [CNT_W-1:0]      act_dec;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign arm_expiry = tick_reg + in_data.timeout;
    assign arm_reject = (PTR_W'(in_data.timer_id) >= PTR_W'(NUM_TIMERS)) ||
                        armed_reg[in_data.timer_id];
    assign cas_bkt    = BKT_W'(ROOT_SIZE) + (BKT_W'(lvi_reg) << LEVEL_BITS) +
                        BKT_W'(lpos_reg[lvi_reg]);
    assign lpos_inc   = lpos_reg[lvi_reg] + LEVEL_BITS'(1);
    assign act_inc    = active_reg + CNT_W'(1);
    assign act_dec    = (active_reg != '0) ? active_reg - CNT_W'(1) : active_reg;

    // The shared selector always looks at the expiry being placed.
    htw_bucket_sel u_bucket_sel (
        .expiry (exp_reg),
        .tick   (tick_reg),
        .bucket (bsel)
    );

    htw_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rd)
    );

    htw_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUCKETS)) u_tail_ram (
        .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
        .raddr(bsel), .rdata(tail_rd)
    );

    htw_ram #(.WIDTH(PTR_W), .DEPTH(NUM_TIMERS)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(cur_reg[ID_W-1:0]), .rdata(next_rd)
    );

    htw_ram #(.WIDTH(TICK_W), .DEPTH(NUM_TIMERS)) u_exp_ram (
        .clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_wdata),
        .raddr(cur_reg[ID_W-1:0]), .rdata(exp_rd)
    );

    // Memory write and read address control.
    always_comb
    begin
        head_we    = 1'b0;
        tail_we    = 1'b0;
        next_we    = 1'b0;
        exp_we     = 1'b0;
        head_waddr = bkt_reg;
        tail_waddr = bkt_reg;
        head_wdata = NIL;
        tail_wdata = NIL;
        next_waddr = cur_reg[ID_W-1:0];
        next_wdata = NIL;
        exp_waddr  = in_data.timer_id;
        exp_wdata  = arm_expiry;
        head_raddr = bsel;
        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                tail_we    = 1'b1;
                head_waddr = clr_reg;
                tail_waddr = clr_reg;
            end
            S_IDLE:
            begin
                exp_we = in_acc && (in_data.command == CMD_ARM) && !arm_reject;
            end
            S_PLACE1:
            begin
                next_we    = 1'b1;
                head_we    = (head_rd == NIL);
                head_wdata = cur_reg;
                tail_we    = 1'b1;
                tail_wdata = cur_reg;
            end
            S_PLACE2:
            begin
                // Link the new entry behind the old tail.
                next_we    = 1'b1;
                next_waddr = tmp_reg[ID_W-1:0];
                next_wdata = cur_reg;
            end
            S_CAS0:
            begin
                head_raddr = cas_bkt;
            end
            S_DRAIN0:
            begin
                head_raddr = BKT_W'(tick_reg[ROOT_BITS-1:0]);
            end
            S_CAS1, S_DRAIN1:
            begin
                // Detach the whole bucket before walking it.
                head_we = 1'b1;
                tail_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            cur_reg       <= NIL;
            nxt_reg       <= NIL;
            tmp_reg       <= NIL;
            exp_reg       <= '0;
            bkt_reg       <= '0;
            clr_reg       <= '0;
            lvi_reg       <= '0;
            cas_reg       <= 1'b0;
            any_reg       <= 1'b0;
            tick_reg      <= '0;
            armed_reg     <= '0;
            active_reg    <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int i = 0; i < NUM_LEVELS - 1; i++)
            begin
                lpos_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BKT_W'(1);
                    if (clr_reg == BKT_W'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (in_data.command == CMD_TICK)
                        begin
                            lvi_reg   <= '0;
                            state_reg <= (tick_reg[ROOT_BITS-1:0] == '0) ? S_CAS0
                                                                         : S_DRAIN0;
                        end
                        else if (arm_reject)
                        begin
                            out_data_reg.kind         <= KIND_REJECTED;
                            out_data_reg.timer_id_res <= in_data.timer_id;
                            out_data_reg.active_count <= active_reg;
                            out_data_reg.peak_count   <= peak_reg;
                            out_data_reg.last         <= 1'b1;
                            out_valid_reg             <= 1'b1;
                            ret_reg                   <= S_IDLE;
                            state_reg                 <= S_OUT;
                        end
                        else
                        begin
                            armed_reg[in_data.timer_id] <= 1'b1;
                            cur_reg   <= PTR_W'(in_data.timer_id);
                            exp_reg   <= arm_expiry;
                            cas_reg   <= 1'b0;
                            state_reg <= S_PLACE0;
                        end
                    end
                end
                S_PLACE0:
                begin
                    bkt_reg   <= bsel;
                    state_reg <= S_PLACE1;
                end
                S_PLACE1:
                begin
                    tmp_reg   <= tail_rd;
                    state_reg <= (head_rd == NIL) ? S_PLACED : S_PLACE2;
                end
                S_PLACE2:
                begin
                    state_reg <= S_PLACED;
                end
                S_PLACED:
                begin
                    if (cas_reg)
                    begin
                        cur_reg   <= nxt_reg;
                        state_reg <= S_CAS_NEXT;
                    end
                    else
                    begin
                        active_reg <= act_inc;
                        if (act_inc > peak_reg)
                        begin
                            peak_reg <= act_inc;
                        end
                        out_data_reg.kind         <= KIND_ARMED;
                        out_data_reg.timer_id_res <= cur_reg[ID_W-1:0];
                        out_data_reg.active_count <= act_inc;
                        out_data_reg.peak_count   <= (act_inc > peak_reg) ? act_inc
                                                                          : peak_reg;
                        out_data_reg.last         <= 1'b1;
                        out_valid_reg             <= 1'b1;
                        ret_reg                   <= S_IDLE;
                        state_reg                 <= S_OUT;
                    end
                end
                S_CAS0:
                begin
                    bkt_reg   <= cas_bkt;
                    state_reg <= S_CAS1;
                end
                S_CAS1:
                begin
                    cur_reg   <= head_rd;
                    state_reg <= S_CAS_NEXT;
                end
                S_CAS_NEXT:
                begin
                    if (cur_reg == NIL)
                    begin
                        lpos_reg[lvi_reg] <= lpos_inc;
                        // A higher level cascades when this one just stepped to one.
                        if (lpos_inc == LEVEL_BITS'(1) &&
                            lvi_reg != LVI_W'(NUM_LEVELS - 2))
                        begin
                            lvi_reg   <= lvi_reg + LVI_W'(1);
                            state_reg <= S_CAS0;
                        end
                        else
                        begin
                            state_reg <= S_DRAIN0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CAS_RD;
                    end
                end
                S_CAS_RD:
                begin
                    nxt_reg   <= next_rd;
                    exp_reg   <= exp_rd;
                    cas_reg   <= 1'b1;
                    state_reg <= S_PLACE0;
                end
                S_DRAIN0:
                begin
                    bkt_reg   <= BKT_W'(tick_reg[ROOT_BITS-1:0]);
                    any_reg   <= 1'b0;
                    state_reg <= S_DRAIN1;
                end
                S_DRAIN1:
                begin
                    cur_reg   <= head_rd;
                    state_reg <= S_DRAIN_NEXT;
                end
                S_DRAIN_NEXT:
                begin
                    if (cur_reg == NIL)
                    begin
                        tick_reg <= tick_reg + TICK_W'(1);
                        if (any_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_data_reg.kind         <= KIND_NONE;
                            out_data_reg.timer_id_res <= '0;
                            out_data_reg.active_count <= active_reg;
                            out_data_reg.peak_count   <= peak_reg;
                            out_data_reg.last         <= 1'b1;
                            out_valid_reg             <= 1'b1;
                            ret_reg                   <= S_IDLE;
                            state_reg                 <= S_OUT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DRAIN_RD;
                    end
                end
                S_DRAIN_RD:
                begin
                    armed_reg[cur_reg[ID_W-1:0]] <= 1'b0;
                    active_reg                <= act_dec;
                    out_data_reg.kind         <= KIND_EXPIRED;
                    out_data_reg.timer_id_res <= cur_reg[ID_W-1:0];
                    out_data_reg.active_count <= act_dec;
                    out_data_reg.peak_count   <= peak_reg;
                    out_data_reg.last         <= (next_rd == NIL);
                    out_valid_reg             <= 1'b1;
                    any_reg                   <= 1'b1;
                    cur_reg                   <= next_rd;
                    ret_reg                   <= S_DRAIN_NEXT;
                    state_reg                 <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A result is only presented while the sequencer waits for it to drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside of output wait");

    // Between commands the active count matches the armed slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(armed_reg) == int'(active_reg)))
        else $error("active count disagrees with armed slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= active_reg)
        else $error("peak count below active count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_NEXT && cur_reg == NIL) |=> (tick_reg == $past(tick_reg) + 1))
        else $error("tick did not advance after bucket drain");

endmodule
